>>> hw/rtl/cdconv_pkg.sv
// ----------------------------------------------------------------------------
// cdconv_pkg: shared types, constants and microcode for the date converter
// Holds the control word layout, the microprogram ROM, status/control
// bundles between sequencer and datapath, and the month length table.
// ----------------------------------------------------------------------------
`default_nettype none

package cdconv_pkg;

    // Calendar constants
    localparam int          EPOCH_YEAR    = 1970;
    localparam int          YEAR_SPAN_DEF = 256;
    localparam int          IN_DAYNUM_W   = 17;
    localparam int          YEAR_W        = 12;
    localparam int          MONTH_W       = 4;
    localparam int          DAY_W         = 5;
    localparam int          YLEN_W        = 9;
    localparam int          TDATA_W       = 40;

    // Epoch year residues for the leap counters
    localparam logic [1:0]  EPOCH_MOD4    = 2'(EPOCH_YEAR % 4);
    localparam logic [6:0]  EPOCH_MOD100  = 7'(EPOCH_YEAR % 100);
    localparam logic [8:0]  EPOCH_MOD400  = 9'(EPOCH_YEAR % 400);

    localparam logic [3:0]  LAST_MONTH    = 4'd12;

    typedef logic [3:0] upc_t;
    typedef logic [3:0] uop_t;
    typedef logic [3:0] ucond_t;

    // Microprogram addresses
    localparam upc_t PC_IDLE      = 4'd0;
    localparam upc_t PC_CMD       = 4'd1;
    localparam upc_t PC_DCHECK    = 4'd2;
    localparam upc_t PC_DYEAR     = 4'd3;
    localparam upc_t PC_DMONTH    = 4'd4;
    localparam upc_t PC_DDAY      = 4'd5;
    localparam upc_t PC_NYEAR     = 4'd6;
    localparam upc_t PC_NEND      = 4'd7;
    localparam upc_t PC_NMONTH    = 4'd8;
    localparam upc_t PC_EMIT_N2D  = 4'd9;
    localparam upc_t PC_EMIT_FAIL = 4'd10;
    localparam upc_t PC_EMIT_D2N  = 4'd11;

    // Datapath operations
    localparam uop_t OP_NOP       = 4'd0;
    localparam uop_t OP_LOAD      = 4'd1;
    localparam uop_t OP_ADD_YEAR  = 4'd2;
    localparam uop_t OP_ADD_MONTH = 4'd3;
    localparam uop_t OP_ADD_DAY   = 4'd4;
    localparam uop_t OP_SUB_YEAR  = 4'd5;
    localparam uop_t OP_SUB_MONTH = 4'd6;
    localparam uop_t OP_EMIT_N2D  = 4'd7;
    localparam uop_t OP_EMIT_FAIL = 4'd8;
    localparam uop_t OP_EMIT_D2N  = 4'd9;

    // Branch conditions
    localparam ucond_t C_NEVER    = 4'd0;
    localparam ucond_t C_NO_IN    = 4'd1;
    localparam ucond_t C_CMD      = 4'd2;
    localparam ucond_t C_DATE_BAD = 4'd3;
    localparam ucond_t C_Y_EQ_IN  = 4'd4;
    localparam ucond_t C_M_EQ_IN  = 4'd5;
    localparam ucond_t C_DAY_BAD  = 4'd6;
    localparam ucond_t C_NY_STOP  = 4'd7;
    localparam ucond_t C_Y_END    = 4'd8;
    localparam ucond_t C_NM_STOP  = 4'd9;
    localparam ucond_t C_OUT_BUSY = 4'd10;

    // Control word: on condition true jump to tgt_t, else run op and go to tgt_f
    typedef struct packed {
        ucond_t cond;
        uop_t   op;
        upc_t   tgt_t;
        upc_t   tgt_f;
    } uword_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic no_in;
        logic cmd;
        logic date_bad;
        logic y_eq_in;
        logic m_eq_in;
        logic day_bad;
        logic ny_stop;
        logic y_end;
        logic nm_stop;
        logic out_busy;
    } status_t;

    // Sequencer command to the datapath
    typedef struct packed {
        logic exec;
        uop_t op;
    } ctrl_t;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Days in month m (1..12), zero for any other code
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = 5'd0;
        if (m >= 4'd1 && m <= LAST_MONTH) begin
            len = MONTH_LEN[m - 4'd1];
            if (m == 4'd2 && leap) begin
                len = 5'd29;
            end
        end
        return len;
    endfunction

    // Microprogram ROM
    function automatic uword_t ucode_rom(input upc_t pc);
        uword_t w;
        unique case (pc)
            PC_IDLE:      w = '{C_NO_IN,    OP_LOAD,      PC_IDLE,      PC_CMD};
            PC_CMD:       w = '{C_CMD,      OP_NOP,       PC_NYEAR,     PC_DCHECK};
            PC_DCHECK:    w = '{C_DATE_BAD, OP_NOP,       PC_EMIT_FAIL, PC_DYEAR};
            PC_DYEAR:     w = '{C_Y_EQ_IN,  OP_ADD_YEAR,  PC_DMONTH,    PC_DYEAR};
            PC_DMONTH:    w = '{C_M_EQ_IN,  OP_ADD_MONTH, PC_DDAY,      PC_DMONTH};
            PC_DDAY:      w = '{C_DAY_BAD,  OP_ADD_DAY,   PC_EMIT_FAIL, PC_EMIT_D2N};
            PC_NYEAR:     w = '{C_NY_STOP,  OP_SUB_YEAR,  PC_NEND,      PC_NYEAR};
            PC_NEND:      w = '{C_Y_END,    OP_NOP,       PC_EMIT_FAIL, PC_NMONTH};
            PC_NMONTH:    w = '{C_NM_STOP,  OP_SUB_MONTH, PC_EMIT_N2D,  PC_NMONTH};
            PC_EMIT_N2D:  w = '{C_OUT_BUSY, OP_EMIT_N2D,  PC_EMIT_N2D,  PC_IDLE};
            PC_EMIT_FAIL: w = '{C_OUT_BUSY, OP_EMIT_FAIL, PC_EMIT_FAIL, PC_IDLE};
            PC_EMIT_D2N:  w = '{C_OUT_BUSY, OP_EMIT_D2N,  PC_EMIT_D2N,  PC_IDLE};
            default:      w = '{C_NEVER,    OP_NOP,       PC_IDLE,      PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cdconv_sequencer.sv
// ----------------------------------------------------------------------------
// cdconv_sequencer: microprogram counter and branch unit
// Fetches one control word per cycle, tests its condition against the
// datapath flags and picks the next address.
// ----------------------------------------------------------------------------
`default_nettype none

module cdconv_sequencer (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  cdconv_pkg::status_t  status,
    output cdconv_pkg::ctrl_t    ctrl,
    output logic                 in_ready
);

    cdconv_pkg::upc_t   pc_reg;
    cdconv_pkg::upc_t   pc_next;
    cdconv_pkg::uword_t word;
    logic               hit;

    assign word = cdconv_pkg::ucode_rom(pc_reg);

    // Condition select
    always_comb begin
        case (word.cond)
            cdconv_pkg::C_NO_IN:    hit = status.no_in;
            cdconv_pkg::C_CMD:      hit = status.cmd;
            cdconv_pkg::C_DATE_BAD: hit = status.date_bad;
            cdconv_pkg::C_Y_EQ_IN:  hit = status.y_eq_in;
            cdconv_pkg::C_M_EQ_IN:  hit = status.m_eq_in;
            cdconv_pkg::C_DAY_BAD:  hit = status.day_bad;
            cdconv_pkg::C_NY_STOP:  hit = status.ny_stop;
            cdconv_pkg::C_Y_END:    hit = status.y_end;
            cdconv_pkg::C_NM_STOP:  hit = status.nm_stop;
            cdconv_pkg::C_OUT_BUSY: hit = status.out_busy;
            default:                hit = 1'b0;
        endcase
    end

    assign pc_next   = hit ? word.tgt_t : word.tgt_f;
    assign ctrl.exec = ~hit;
    assign ctrl.op   = word.op;
    assign in_ready  = (pc_reg == cdconv_pkg::PC_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= cdconv_pkg::PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cdconv_datapath.sv
// ----------------------------------------------------------------------------
// cdconv_datapath: request registers, day accumulator and result register
// Runs the sequencer's operation: load, year and month steps that add to or
// take from the accumulator with running leap counters, day add, result write.
// ----------------------------------------------------------------------------
`default_nettype none

module cdconv_datapath #(
    parameter int YEAR_SPAN = cdconv_pkg::YEAR_SPAN_DEF,
    parameter int ACC_W     = 19
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  cdconv_pkg::ctrl_t                 ctrl,
    input  wire                               s_tvalid,
    input  wire [cdconv_pkg::TDATA_W-1:0]     s_tdata,
    input  wire                               s_tuser,
    output cdconv_pkg::status_t               status,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [cdconv_pkg::TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser
);

    localparam logic [11:0] EPOCH    = 12'(cdconv_pkg::EPOCH_YEAR);
    localparam logic [11:0] END_YEAR = 12'(cdconv_pkg::EPOCH_YEAR + YEAR_SPAN);

    // Request fields
    logic        in_cmd_reg;
    logic [11:0] in_year_reg;
    logic [3:0]  in_month_reg;
    logic [4:0]  in_day_reg;
    logic [16:0] in_num_reg;

    // Working registers
    logic [ACC_W-1:0] acc_reg;
    logic [11:0]      y_reg;
    logic [3:0]       m_reg;
    logic [1:0]       c4_reg;
    logic [6:0]       c100_reg;
    logic [8:0]       c400_reg;

    // Result register
    logic        m_tvalid_reg;
    logic [16:0] out_num_reg;
    logic [11:0] out_year_reg;
    logic [3:0]  out_month_reg;
    logic [4:0]  out_day_reg;
    logic        out_ok_reg;

    logic                          leap;
    logic [cdconv_pkg::YLEN_W-1:0] ylen;
    logic [4:0]                    mlen;
    logic [ACC_W-1:0]              acc_add_y;
    logic [ACC_W-1:0]              acc_sub_y;
    logic [ACC_W-1:0]              acc_add_m;
    logic [ACC_W-1:0]              acc_sub_m;
    logic                          emit;
    logic                          run;

    assign run  = ctrl.exec;
    assign emit = run && (ctrl.op == cdconv_pkg::OP_EMIT_N2D ||
                          ctrl.op == cdconv_pkg::OP_EMIT_FAIL ||
                          ctrl.op == cdconv_pkg::OP_EMIT_D2N);

    // Leap rule from running residues of the current year
    assign leap = ((c4_reg == 2'd0) && (c100_reg != 7'd0)) || (c400_reg == 9'd0);
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = cdconv_pkg::month_days(m_reg, leap);

    assign acc_add_y = acc_reg + ACC_W'(ylen);
    assign acc_sub_y = acc_reg - ACC_W'(ylen);
    assign acc_add_m = acc_reg + ACC_W'(mlen);
    assign acc_sub_m = acc_reg - ACC_W'(mlen);

    // Flags for the branch unit
    assign status.no_in    = ~s_tvalid;
    assign status.cmd      = in_cmd_reg;
    assign status.date_bad = (in_year_reg < EPOCH) || (in_year_reg >= END_YEAR) ||
                             (in_month_reg == 4'd0) ||
                             (in_month_reg > cdconv_pkg::LAST_MONTH);
    assign status.y_eq_in  = (y_reg == in_year_reg);
    assign status.m_eq_in  = (m_reg == in_month_reg);
    assign status.day_bad  = (in_day_reg == 5'd0) || (in_day_reg > mlen);
    assign status.y_end    = (y_reg == END_YEAR);
    assign status.ny_stop  = status.y_end || (acc_reg < ACC_W'(ylen));
    assign status.nm_stop  = (m_reg == cdconv_pkg::LAST_MONTH) || (acc_reg < ACC_W'(mlen));
    assign status.out_busy = m_tvalid_reg && !m_tready;

    // Operation execution
    always_ff @(posedge aclk) begin
        if (run) begin
            unique case (ctrl.op) inside
                cdconv_pkg::OP_LOAD: begin
                    in_cmd_reg   <= s_tuser;
                    in_year_reg  <= s_tdata[11:0];
                    in_month_reg <= s_tdata[15:12];
                    in_day_reg   <= s_tdata[20:16];
                    in_num_reg   <= s_tdata[37:21];
                    acc_reg      <= s_tuser ? ACC_W'(s_tdata[37:21]) : '0;
                    y_reg        <= EPOCH;
                    m_reg        <= 4'd1;
                    c4_reg       <= cdconv_pkg::EPOCH_MOD4;
                    c100_reg     <= cdconv_pkg::EPOCH_MOD100;
                    c400_reg     <= cdconv_pkg::EPOCH_MOD400;
                end
                cdconv_pkg::OP_ADD_YEAR, cdconv_pkg::OP_SUB_YEAR: begin
                    acc_reg  <= (ctrl.op == cdconv_pkg::OP_SUB_YEAR) ? acc_sub_y : acc_add_y;
                    y_reg    <= y_reg + 12'd1;
                    c4_reg   <= c4_reg + 2'd1;
                    c100_reg <= (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                    c400_reg <= (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                end
                cdconv_pkg::OP_ADD_MONTH, cdconv_pkg::OP_SUB_MONTH: begin
                    acc_reg <= (ctrl.op == cdconv_pkg::OP_SUB_MONTH) ? acc_sub_m : acc_add_m;
                    m_reg   <= m_reg + 4'd1;
                end
                cdconv_pkg::OP_ADD_DAY: begin
                    acc_reg <= acc_reg + ACC_W'(in_day_reg - 5'd1);
                end
                cdconv_pkg::OP_EMIT_N2D: begin
                    out_num_reg   <= in_num_reg;
                    out_year_reg  <= y_reg;
                    out_month_reg <= m_reg;
                    out_day_reg   <= acc_reg[4:0] + 5'd1;
                    out_ok_reg    <= 1'b1;
                end
                cdconv_pkg::OP_EMIT_D2N: begin
                    out_num_reg   <= acc_reg[16:0];
                    out_year_reg  <= in_year_reg;
                    out_month_reg <= in_month_reg;
                    out_day_reg   <= in_day_reg;
                    out_ok_reg    <= 1'b1;
                end
                cdconv_pkg::OP_EMIT_FAIL: begin
                    out_num_reg   <= '0;
                    out_year_reg  <= '0;
                    out_month_reg <= '0;
                    out_day_reg   <= '0;
                    out_ok_reg    <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_day_reg, out_month_reg, out_year_reg, out_num_reg};
    assign m_tuser  = out_ok_reg;

endmodule

`default_nettype wire

>>> hw/rtl/civil_date_day_number_converter_unit.sv
// ----------------------------------------------------------------------------
// civil_date_day_number_converter_unit: Gregorian date <-> day number
// Converts a date to days since 1970-01-01 and back, checking the span.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the s_ channel; s_tuser selects the direction
//   (0 = date to day number, 1 = day number to date). Each request gives
//   exactly one result on the m_ channel; m_tuser is 1 for a well-formed date
//   or a day number inside the years 1970 .. 1970 + YEAR_SPAN - 1, else every
//   result field is zero.
//   A small microprogram steps the day accumulator one year or one month
//   per cycle. A day number passes the load, command, year walk, end check,
//   month walk and emit steps; a date passes the load, command, date check,
//   year walk, month walk, day and emit steps; the year walk is the longest.
//   One request is worked at a time; s_tready is high only in the idle step.
//   The result sits in an output register, so a new request is taken while
//   the previous result waits; if the receiver stalls, the sequencer holds
//   in its emit step until it frees.
//   Reset (aresetn low, synchronous) returns the sequencer to idle and
//   drops m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module civil_date_day_number_converter_unit #(
    parameter int YEAR_SPAN = cdconv_pkg::YEAR_SPAN_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // in_year[11:0], in_month[15:12], in_day[20:16], in_day_number[37:21]
    input  wire [cdconv_pkg::TDATA_W-1:0]   s_tdata,
    // cmd[0]
    input  wire                             s_tuser,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // out_day_number[16:0], out_year[28:17], out_month[32:29], out_day[37:33]
    output logic [cdconv_pkg::TDATA_W-1:0]  m_tdata,
    // valid_res[0]
    output logic                            m_tuser
);

    localparam int SPAN_BITS = $clog2(YEAR_SPAN * 366 + 1);
    localparam int ACC_W     = (SPAN_BITS > cdconv_pkg::IN_DAYNUM_W) ?
                               SPAN_BITS : cdconv_pkg::IN_DAYNUM_W;

    cdconv_pkg::status_t status;
    cdconv_pkg::ctrl_t   ctrl;

    cdconv_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status   (status),
        .ctrl     (ctrl),
        .in_ready (s_tready)
    );

    cdconv_datapath #(
        .YEAR_SPAN (YEAR_SPAN),
        .ACC_W     (ACC_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for civil_date_day_number_converter_unit
// Drives date and day-number requests on the s_ stream and checks every
// result on the m_ stream against a cycle-free calendar predictor. It covers
// directed calendar corners, random traffic under three idling profiles, and
// a long receiver stall that backs the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    // Direction codes carried on tuser
    localparam logic CMD_DATE_TO_NUM = 1'b0;
    localparam logic CMD_NUM_TO_DATE = 1'b1;

    localparam int SPAN_END      = cdconv_pkg::EPOCH_YEAR + cdconv_pkg::YEAR_SPAN_DEF;
    localparam int LAST_DAY_NUM  = 93501;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 600;
    localparam int DRAIN_CYCLES  = cdconv_pkg::YEAR_SPAN_DEF + 40;
    localparam int RANDOM_ITEMS  = 260;

    typedef struct packed {
        logic                               cmd;
        logic [cdconv_pkg::YEAR_W-1:0]      year;
        logic [cdconv_pkg::MONTH_W-1:0]     month;
        logic [cdconv_pkg::DAY_W-1:0]       day;
        logic [cdconv_pkg::IN_DAYNUM_W-1:0] day_number;
    } conv_request_t;

    typedef struct packed {
        logic [cdconv_pkg::IN_DAYNUM_W-1:0] day_number;
        logic [cdconv_pkg::YEAR_W-1:0]      year;
        logic [cdconv_pkg::MONTH_W-1:0]     month;
        logic [cdconv_pkg::DAY_W-1:0]       day;
        logic                               ok;
    } conv_result_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [cdconv_pkg::TDATA_W-1:0]   s_tdata  = '0;
    logic                             s_tuser  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [cdconv_pkg::TDATA_W-1:0]   m_tdata;
    logic                             m_tuser;

    conv_result_t pending_results[$];
    int           mismatch_count = 0;
    int           send_idle_pct  = 37;
    int           recv_idle_pct  = 71;
    int           hold_asked     = 0;
    int           hold_taken     = 0;
    int           hold_left      = 0;
    int           quiet_cycles   = 0;

    civil_date_day_number_converter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Gregorian leap rule
    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Days in month m of year y, zero for a bad month code
    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Expected result of one request
    function automatic conv_result_t civil_convert(input conv_request_t rq);
        conv_result_t r;
        int unsigned  acc;
        int unsigned  rem;
        int unsigned  y;
        int unsigned  m;
        r = '0;
        if (rq.cmd == CMD_DATE_TO_NUM) begin
            if (rq.year >= cdconv_pkg::EPOCH_YEAR && rq.year < SPAN_END && rq.month >= 1 &&
                rq.month <= 12 && rq.day >= 1 &&
                rq.day <= days_in_month(rq.year, rq.month)) begin
                acc = 0;
                for (y = cdconv_pkg::EPOCH_YEAR; y < rq.year; y++)
                    acc += is_leap(y) ? 366 : 365;
                for (m = 1; m < rq.month; m++) acc += days_in_month(rq.year, m);
                acc += rq.day - 1;
                r.day_number = acc[cdconv_pkg::IN_DAYNUM_W-1:0];
                r.year       = rq.year;
                r.month      = rq.month;
                r.day        = rq.day;
                r.ok         = 1'b1;
            end
        end else begin
            rem = rq.day_number;
            y   = cdconv_pkg::EPOCH_YEAR;
            while (y < SPAN_END && rem >= (is_leap(y) ? 366 : 365)) begin
                rem -= is_leap(y) ? 366 : 365;
                y++;
            end
            if (y < SPAN_END) begin
                m = 1;
                while (m < 12 && rem >= days_in_month(y, m)) begin
                    rem -= days_in_month(y, m);
                    m++;
                end
                r.day_number = rq.day_number;
                r.year       = y[cdconv_pkg::YEAR_W-1:0];
                r.month      = m[cdconv_pkg::MONTH_W-1:0];
                r.day        = 5'(rem + 1);
                r.ok         = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic conv_request_t make_date(input int unsigned y, input int unsigned m,
                                                input int unsigned d);
        conv_request_t rq;
        int unsigned   noise;
        noise         = $urandom;
        rq.cmd        = CMD_DATE_TO_NUM;
        rq.year       = y[cdconv_pkg::YEAR_W-1:0];
        rq.month      = m[cdconv_pkg::MONTH_W-1:0];
        rq.day        = d[cdconv_pkg::DAY_W-1:0];
        rq.day_number = noise[cdconv_pkg::IN_DAYNUM_W-1:0];
        return rq;
    endfunction

    function automatic conv_request_t make_day_number(input int unsigned n);
        conv_request_t rq;
        int unsigned   noise;
        rq.cmd        = CMD_NUM_TO_DATE;
        noise         = $urandom;
        rq.year       = noise[cdconv_pkg::YEAR_W-1:0];
        noise         = $urandom;
        rq.month      = noise[cdconv_pkg::MONTH_W-1:0];
        noise         = $urandom;
        rq.day        = noise[cdconv_pkg::DAY_W-1:0];
        rq.day_number = n[cdconv_pkg::IN_DAYNUM_W-1:0];
        return rq;
    endfunction

    // Mostly well-formed requests with random content, some raw noise
    function automatic conv_request_t random_request(input int unsigned max_years);
        conv_request_t rq;
        int unsigned   y;
        int unsigned   m;
        int unsigned   pick;
        int unsigned   noise;
        pick = $urandom_range(99);
        y    = cdconv_pkg::EPOCH_YEAR + $urandom_range(max_years - 1);
        m    = $urandom_range(12, 1);
        if (pick < 35) begin
            rq = make_date(y, m, $urandom_range(days_in_month(y, m), 1));
        end else if (pick < 45) begin
            // month end and the day just past it
            rq = make_date(y, m, days_in_month(y, m) + $urandom_range(1));
        end else if (pick < 80) begin
            rq = make_day_number($urandom_range(max_years * 365));
        end else if (pick < 88) begin
            rq = make_day_number($urandom_range(131071, LAST_DAY_NUM - 400));
        end else begin
            rq = conv_request_t'($urandom);
            noise   = $urandom;
            rq.year = noise[cdconv_pkg::YEAR_W-1:0];
        end
        return rq;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offer one request and wait for it to be taken
    task automatic send_request(input conv_request_t rq);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.cmd;
        s_tdata  <= {2'b00, rq.day_number, rq.day, rq.month, rq.year};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(civil_convert(rq));
    endtask

    task automatic wait_results_drained;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random stalls, or a long hold when asked
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_taken) begin
            m_tready   <= 1'b0;
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        conv_result_t exp_r;
        conv_result_t got_r;
        if (aresetn && m_tvalid && m_tready) begin
            got_r.day_number = m_tdata[16:0];
            got_r.year       = m_tdata[28:17];
            got_r.month      = m_tdata[32:29];
            got_r.day        = m_tdata[37:33];
            got_r.ok         = m_tuser;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %p", got_r));
            end else begin
                exp_r = pending_results.pop_front();
                if (got_r.day_number !== exp_r.day_number)
                    report_mismatch($sformatf("day_number exp %0d got %0d",
                                              exp_r.day_number, got_r.day_number));
                if (got_r.year !== exp_r.year)
                    report_mismatch($sformatf("year exp %0d got %0d", exp_r.year, got_r.year));
                if (got_r.month !== exp_r.month)
                    report_mismatch($sformatf("month exp %0d got %0d",
                                              exp_r.month, got_r.month));
                if (got_r.day !== exp_r.day)
                    report_mismatch($sformatf("day exp %0d got %0d", exp_r.day, got_r.day));
                if (got_r.ok !== exp_r.ok)
                    report_mismatch($sformatf("valid exp %0d got %0d", exp_r.ok, got_r.ok));
            end
        end
    end

    // Watchdog on cycles with no request or result moving
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Span ends, month and day limits, leap rule corners
    task automatic test_date_edges;
        send_request(make_date(1970, 1, 1));
        send_request(make_date(2225, 12, 31));
        send_request(make_date(2226, 1, 1));
        send_request(make_date(1969, 12, 31));
        send_request(make_date(0, 0, 0));
        send_request(make_date(4095, 15, 31));
        send_request(make_date(2001, 0, 10));
        send_request(make_date(2001, 13, 10));
        send_request(make_date(2001, 6, 0));
        send_request(make_date(2001, 4, 31));
        send_request(make_date(2000, 2, 29));
        send_request(make_date(2100, 2, 29));
        send_request(make_date(2024, 2, 29));
        send_request(make_date(2023, 2, 29));
    endtask

    // Day numbers at the span ends, beyond it, and around leap days
    task automatic test_day_number_edges;
        send_request(make_day_number(0));
        send_request(make_day_number(LAST_DAY_NUM));
        send_request(make_day_number(LAST_DAY_NUM + 1));
        send_request(make_day_number(131071));
        send_request(make_day_number(59));
        send_request(make_day_number(10957));
        send_request(make_day_number(11016));
        send_request(make_day_number(47540));
        send_request(make_day_number(364));
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (RANDOM_ITEMS) send_request(random_request(cdconv_pkg::YEAR_SPAN_DEF));
        wait_results_drained();
    endtask

    // Receiver holds off while the sender keeps offering short requests
    task automatic test_backpressure_fill;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked++;
        repeat (20) send_request(random_request(4));
        wait_results_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_date_edges();
        test_day_number_edges();
        wait_results_drained();
        test_random_traffic(37, 71);
        test_random_traffic(71, 37);
        test_random_traffic(0, 0);
        test_backpressure_fill();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/cdconv_pkg.sv
hw/rtl/cdconv_sequencer.sv
hw/rtl/cdconv_datapath.sv
hw/rtl/civil_date_day_number_converter_unit.sv
tb/tb.sv
